FILE: design/flpa_pkg.sv
// flpa_pkg: shared constants, types and helpers for the pool allocator
// no dependencies; imported by every module of the block
package flpa_pkg;

  localparam int POOL_MAX_BYTES = 4096;
  localparam int HEADER_BYTES   = 8;
  localparam int NODE_BYTES     = 8;
  localparam int SLOTS          = POOL_MAX_BYTES / NODE_BYTES;
  localparam int SLOT_W         = $clog2(SLOTS);
  localparam int GRAN_W         = $clog2(NODE_BYTES);
  localparam int ADDR_W         = 13;
  localparam int CNT_W          = 13;
  localparam int DADDR_W        = 12;
  localparam int STEP_W         = SLOT_W + 1;
  localparam int PROD_W         = 2 * CNT_W;

  // request and status codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;

  // pool control from the register side to the engine
  typedef struct packed {
    logic              clr_req;
    logic [ADDR_W-1:0] pool;
  } pool_ctl_t;

  // sizing result from the multiply unit
  typedef struct packed {
    logic              too_big;
    logic [ADDR_W-1:0] total;
  } size_res_t;

  // node store entry index of a pool offset
  function automatic logic [SLOT_W-1:0] slot_of(input logic [ADDR_W-1:0] pos);
    slot_of = pos[GRAN_W +: SLOT_W];
  endfunction

endpackage

FILE: design/flpa_size.sv
// flpa_size: block size of an allocate request (count * bytes + header, rounded)
// depends on flpa_pkg
module flpa_size import flpa_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic [CNT_W-1:0] item_count,
  input  logic [CNT_W-1:0] item_bytes,
  input  logic [ADDR_W-1:0] pool,
  output size_res_t        res
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W:0]   t_sum;
  logic [PROD_W:0]   t_round;

  // product registered on the accepted transfer
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(item_count) * PROD_W'(item_bytes);
    end
  end

  // add header, round up to a whole granule, compare with the pool
  always_comb begin
    t_sum   = {1'b0, prod_r} + (PROD_W+1)'(HEADER_BYTES + NODE_BYTES - 1);
    t_round = {t_sum[PROD_W:GRAN_W], {GRAN_W{1'b0}}};
    res.too_big = t_round > {{(PROD_W+1-ADDR_W){1'b0}}, pool};
    res.total   = t_round[ADDR_W-1:0];
  end

endmodule

FILE: design/flpa_engine.sv
// flpa_engine: node store memory and the sequencer that walks the free list
// depends on flpa_pkg
module flpa_engine import flpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pool_ctl_t         ctl,
  input  logic              start,
  output logic              busy,
  output logic              size_load,
  input  size_res_t         sz,
  input  logic              in_req_type,
  input  logic [DADDR_W-1:0] in_free_addr,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [DADDR_W-1:0] out_data_addr
);

  typedef enum logic [22:0] {
    S_CLR   = 23'd1 << 0,
    S_IDLE  = 23'd1 << 1,
    S_ASIZE = 23'd1 << 2,
    S_AHD   = 23'd1 << 3,
    S_ARD   = 23'd1 << 4,
    S_AEV   = 23'd1 << 5,
    S_APASS = 23'd1 << 6,
    S_AM1   = 23'd1 << 7,
    S_AW1   = 23'd1 << 8,
    S_AW2   = 23'd1 << 9,
    S_AW3   = 23'd1 << 10,
    S_FCHK  = 23'd1 << 11,
    S_FTOT  = 23'd1 << 12,
    S_FWRD  = 23'd1 << 13,
    S_FWEV  = 23'd1 << 14,
    S_FPRD  = 23'd1 << 15,
    S_FPEV  = 23'd1 << 16,
    S_FW1   = 23'd1 << 17,
    S_FW2   = 23'd1 << 18,
    S_FSRD  = 23'd1 << 19,
    S_FSEV  = 23'd1 << 20,
    S_FNX   = 23'd1 << 21,
    S_FNEV  = 23'd1 << 22
  } state_t;

  state_t state_r, state_nxt;

  // node store, next and size fields written separately
  logic [ADDR_W-1:0] mem_next [SLOTS];
  logic [ADDR_W-1:0] mem_size [SLOTS];
  logic [SLOT_W-1:0] ra, wa;
  logic              we_next, we_size;
  logic [ADDR_W-1:0] wd_next, wd_size;
  logic [ADDR_W-1:0] rn_r, rs_r;

  // walk registers
  logic [SLOT_W-1:0]  clr_r, clr_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic               pass_r, pass_nxt;
  logic [ADDR_W-1:0]  prev_r, prev_nxt;
  logic [ADDR_W-1:0]  cur_r, cur_nxt;
  logic [ADDR_W-1:0]  cn_r, cn_nxt;
  logic [ADDR_W-1:0]  csz_r, csz_nxt;
  logic [ADDR_W-1:0]  tot_r, tot_nxt;
  logic [ADDR_W-1:0]  blk_r, blk_nxt;
  logic [DADDR_W-1:0] fa_r;

  logic               ov_r, ov_nxt;
  logic [1:0]         ost_r, ost_nxt;
  logic [DADDR_W-1:0] oad_r, oad_nxt;

  logic [ADDR_W-1:0]  fa_ext, blk_c, np_c;
  logic               a_hit, done;

  // memory ports
  always_ff @(posedge clk) begin
    if (we_next) begin
      mem_next[wa] <= wd_next;
    end
    if (we_size) begin
      mem_size[wa] <= wd_size;
    end
    rn_r <= mem_next[ra];
    rs_r <= mem_size[ra];
  end

  // request payload kept for the walk
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      fa_r <= in_free_addr;
    end
  end

  // a pending clear also holds off requests
  assign busy      = (state_r != S_IDLE) || ctl.clr_req;
  assign size_load = start && !busy;
  assign fa_ext    = {{(ADDR_W-DADDR_W){1'b0}}, fa_r};
  assign blk_c     = fa_ext - ADDR_W'(HEADER_BYTES);
  assign np_c      = cur_r + sz.total;
  assign a_hit     = pass_r ? (rs_r > sz.total) : (rs_r == sz.total);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    steps_nxt = steps_r;
    pass_nxt  = pass_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    cn_nxt    = cn_r;
    csz_nxt   = csz_r;
    tot_nxt   = tot_r;
    blk_nxt   = blk_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    oad_nxt   = oad_r;
    ra        = '0;
    wa        = '0;
    we_next   = 1'b0;
    we_size   = 1'b0;
    wd_next   = '0;
    wd_size   = '0;
    done      = 1'b0;

    case (state_r)
      S_CLR: begin
        // clearing pass: anchor, one whole free block, zeros elsewhere
        wa      = clr_r;
        we_next = 1'b1;
        we_size = 1'b1;
        wd_next = (clr_r == SLOT_W'(0)) ? ADDR_W'(NODE_BYTES) : '0;
        wd_size = (clr_r == SLOT_W'(1)) ? ctl.pool - ADDR_W'(NODE_BYTES) : '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          pass_nxt  = 1'b0;
          state_nxt = (in_req_type == REQ_FREE) ? S_FCHK : S_ASIZE;
        end
      end
      S_ASIZE: begin
        ra = '0;
        if (sz.too_big) begin
          ost_nxt = ST_NOFIT;
          oad_nxt = '0;
          done    = 1'b1;
        end else begin
          state_nxt = S_AHD;
        end
      end
      S_APASS: begin
        ra        = '0;
        state_nxt = S_AHD;
      end
      S_AHD: begin
        prev_nxt  = '0;
        cur_nxt   = rn_r;
        steps_nxt = '0;
        state_nxt = S_ARD;
      end
      S_ARD: begin
        ra = slot_of(cur_r);
        if (cur_r == '0 || steps_r == STEP_W'(SLOTS)) begin
          if (pass_r) begin
            ost_nxt = ST_NOFIT;
            oad_nxt = '0;
            done    = 1'b1;
          end else begin
            pass_nxt  = 1'b1;
            state_nxt = S_APASS;
          end
        end else begin
          state_nxt = S_AEV;
        end
      end
      S_AEV: begin
        cn_nxt  = rn_r;
        csz_nxt = rs_r;
        if (a_hit) begin
          state_nxt = pass_r ? S_AW1 : S_AM1;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = rn_r;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_ARD;
        end
      end
      S_AM1: begin
        // exact fit: unlink
        wa        = slot_of(prev_r);
        we_next   = 1'b1;
        wd_next   = cn_r;
        state_nxt = S_AW3;
      end
      S_AW1: begin
        // split: tail stays free
        wa        = slot_of(np_c);
        we_next   = 1'b1;
        we_size   = 1'b1;
        wd_next   = cn_r;
        wd_size   = csz_r - sz.total;
        state_nxt = S_AW2;
      end
      S_AW2: begin
        wa        = slot_of(prev_r);
        we_next   = 1'b1;
        wd_next   = np_c;
        state_nxt = S_AW3;
      end
      S_AW3: begin
        // header of the allocated block
        wa      = slot_of(cur_r);
        we_next = 1'b1;
        we_size = 1'b1;
        wd_next = '0;
        wd_size = sz.total;
        ost_nxt = ST_ALLOC;
        oad_nxt = DADDR_W'(cur_r + ADDR_W'(HEADER_BYTES));
        done    = 1'b1;
      end
      S_FCHK: begin
        ost_nxt = ST_FREED;
        oad_nxt = '0;
        blk_nxt = blk_c;
        ra      = slot_of(blk_c);
        if (fa_ext < ADDR_W'(HEADER_BYTES) || blk_c < ADDR_W'(NODE_BYTES) ||
            blk_c[GRAN_W-1:0] != '0 || blk_c >= ctl.pool) begin
          done = 1'b1;
        end else begin
          state_nxt = S_FTOT;
        end
      end
      S_FTOT: begin
        tot_nxt   = rs_r;
        prev_nxt  = '0;
        steps_nxt = '0;
        if (rs_r == '0 || rs_r[GRAN_W-1:0] != '0 || rs_r > ctl.pool - blk_r) begin
          done = 1'b1;
        end else begin
          state_nxt = S_FWRD;
        end
      end
      S_FWRD: begin
        ra        = slot_of(prev_r);
        state_nxt = S_FWEV;
      end
      S_FWEV: begin
        // find the last node below the block
        if (rn_r == '0 || rn_r >= blk_r) begin
          state_nxt = S_FPRD;
        end else begin
          prev_nxt  = rn_r;
          steps_nxt = steps_r + 1'b1;
          state_nxt = (steps_r == STEP_W'(SLOTS - 1)) ? S_FPRD : S_FWRD;
        end
      end
      S_FPRD: begin
        ra        = slot_of(prev_r);
        state_nxt = S_FPEV;
      end
      S_FPEV: begin
        cn_nxt = rn_r;
        if (rn_r == blk_r) begin
          done = 1'b1;
        end else begin
          state_nxt = S_FW1;
        end
      end
      S_FW1: begin
        // link the block in
        wa        = slot_of(blk_r);
        we_next   = 1'b1;
        we_size   = 1'b1;
        wd_next   = cn_r;
        wd_size   = tot_r;
        state_nxt = S_FW2;
      end
      S_FW2: begin
        wa        = slot_of(prev_r);
        we_next   = 1'b1;
        wd_next   = blk_r;
        state_nxt = S_FSRD;
      end
      S_FSRD: begin
        ra        = slot_of(prev_r);
        state_nxt = S_FSEV;
      end
      S_FSEV: begin
        // merge with the predecessor when adjacent
        if ({1'b0, prev_r} + {1'b0, rs_r} == {1'b0, blk_r}) begin
          wa      = slot_of(prev_r);
          we_next = 1'b1;
          we_size = 1'b1;
          wd_next = cn_r;
          wd_size = rs_r + tot_r;
          cur_nxt = prev_r;
          csz_nxt = rs_r + tot_r;
        end else begin
          cur_nxt = blk_r;
          csz_nxt = tot_r;
        end
        state_nxt = S_FNX;
      end
      S_FNX: begin
        ra = slot_of(cn_r);
        if (cn_r != '0 && {1'b0, cur_r} + {1'b0, csz_r} == {1'b0, cn_r}) begin
          state_nxt = S_FNEV;
        end else begin
          done = 1'b1;
        end
      end
      S_FNEV: begin
        // merge with the successor
        wa      = slot_of(cur_r);
        we_next = 1'b1;
        we_size = 1'b1;
        wd_next = rn_r;
        wd_size = csz_r + rs_r;
        done    = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      ov_nxt    = 1'b1;
      state_nxt = S_IDLE;
    end
    if (ctl.clr_req) begin
      state_nxt = S_CLR;
      clr_nxt   = '0;
      ov_nxt    = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    pass_r  <= pass_nxt;
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    cn_r    <= cn_nxt;
    csz_r   <= csz_nxt;
    tot_r   <= tot_nxt;
    blk_r   <= blk_nxt;
    ost_r   <= ost_nxt;
    oad_r   <= oad_nxt;
  end

  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_data_addr = oad_r;

endmodule

FILE: design/free_list_pool_allocator_unit.sv
// free_list_pool_allocator_unit: top level of the free-list pool allocator (exact fit first, then first larger block)
// depends on flpa_pkg, flpa_size and flpa_engine
//
// Usage: a request is taken at a clock edge with start high and busy low.
// in_req_type selects allocate (in_item_count * in_item_bytes plus header)
// or free (in_free_addr). Exactly one result follows unless a cfg_pool_bytes
// transfer clears the store first: out_valid is high for one cycle with
// out_status and out_data_addr, and the receiver cannot stall it. busy stays
// high from the transfer until the result cycle.
// The list walk reads one node at a time from the node store. An allocate
// first walks the list for an exact fit, then walks it again for the first
// larger block, which it splits; an oversized request is answered without a
// walk. A free walks to the last node below the block, links it in and
// merges it with its predecessor and successor where adjacent; invalid frees
// and blocks already on the list end early.
// A request is taken only once the previous one is answered.
// Reset and every cfg_pool_bytes transfer (cfg_ready is always high) start
// a clearing pass over every node store entry; busy is high from the
// cycle after the transfer until the pass ends.
module free_list_pool_allocator_unit import flpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [CNT_W-1:0]   in_item_count,
  input  logic [CNT_W-1:0]   in_item_bytes,
  input  logic [DADDR_W-1:0] in_free_addr,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [DADDR_W-1:0] out_data_addr,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ADDR_W-1:0]  cfg_pool_bytes
);

  logic [ADDR_W-1:0] pool_r, pool_nxt;
  logic              clr_r, clr_nxt;
  pool_ctl_t         ctl;
  size_res_t         sz;
  logic              size_load;

  assign cfg_ready = 1'b1;

  // clamp the written pool size and round down to a granule
  always_comb begin
    pool_nxt = pool_r;
    clr_nxt  = 1'b0;
    if (cfg_valid) begin
      clr_nxt = 1'b1;
      if (cfg_pool_bytes < ADDR_W'(16)) begin
        pool_nxt = ADDR_W'(16);
      end else if (cfg_pool_bytes > ADDR_W'(POOL_MAX_BYTES)) begin
        pool_nxt = ADDR_W'(POOL_MAX_BYTES);
      end else begin
        pool_nxt = {cfg_pool_bytes[ADDR_W-1:GRAN_W], {GRAN_W{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= ADDR_W'(POOL_MAX_BYTES);
      clr_r  <= 1'b0;
    end else begin
      pool_r <= pool_nxt;
      clr_r  <= clr_nxt;
    end
  end

  assign ctl.clr_req = clr_r;
  assign ctl.pool    = pool_r;

  flpa_size u_size (
    .clk        (clk),
    .load       (size_load),
    .item_count (in_item_count),
    .item_bytes (in_item_bytes),
    .pool       (pool_r),
    .res        (sz)
  );

  flpa_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .start         (start),
    .busy          (busy),
    .size_load     (size_load),
    .sz            (sz),
    .in_req_type   (in_req_type),
    .in_free_addr  (in_free_addr),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_data_addr (out_data_addr)
  );

endmodule

FILE: tb/free_list_pool_allocator_unit_test.sv
// free_list_pool_allocator_unit_test: self-checking bench for the pool allocator
// depends on flpa_pkg and free_list_pool_allocator_unit; random allocate/free traffic
// is checked against a free-list predictor kept in a small scoreboard class
module free_list_pool_allocator_unit_test;
  import flpa_pkg::*;

  typedef struct {
    logic [1:0]         status;
    logic [DADDR_W-1:0] addr;
  } alloc_result_t;

  // free-list predictor plus queue of expected results
  class alloc_scoreboard;
    int unsigned   pool;
    int unsigned   link[SLOTS];
    int unsigned   span[SLOTS];
    alloc_result_t pending_q[$];
    int            mismatches;
    int            n_alloc, n_nofit, n_free, n_checked;

    function int unsigned slot_ix(int unsigned p);
      return (p / NODE_BYTES) % SLOTS;
    endfunction

    function void set_pool(int unsigned v);
      if (v < 16) v = 16;
      if (v > POOL_MAX_BYTES) v = POOL_MAX_BYTES;
      v -= v % NODE_BYTES;
      pool = v;
      foreach (link[i]) begin
        link[i] = 0;
        span[i] = 0;
      end
      link[0] = NODE_BYTES;
      span[slot_ix(NODE_BYTES)] = pool - NODE_BYTES;
    endfunction

    // first exact fit, then first larger block split
    function logic [1:0] take_block(longint unsigned cnt, longint unsigned bytes,
                                    output int unsigned addr);
      longint unsigned need;
      int unsigned total, prev, cur, s, np;
      addr = 0;
      need = cnt * bytes + HEADER_BYTES;
      need = (need + NODE_BYTES - 1) / NODE_BYTES * NODE_BYTES;
      if (need > pool) return ST_NOFIT;
      total = need;
      for (int pass = 0; pass < 2; pass++) begin
        prev = 0;
        cur = link[0];
        for (int k = 0; k < SLOTS && cur != 0; k++) begin
          s = slot_ix(cur);
          if (pass == 0 && span[s] == total) begin
            link[slot_ix(prev)] = link[s];
          end else if (pass == 1 && span[s] > total) begin
            np = cur + total;
            link[slot_ix(np)] = link[s];
            span[slot_ix(np)] = span[s] - total;
            link[slot_ix(prev)] = np;
          end else begin
            prev = cur;
            cur = link[s];
            continue;
          end
          span[s] = total;
          link[s] = 0;
          addr = cur + HEADER_BYTES;
          return ST_ALLOC;
        end
      end
      return ST_NOFIT;
    endfunction

    // address-ordered insert with merge on both sides
    function void give_back(int unsigned fa);
      int unsigned blk, tot, prev, cur, cs, ps, np, ns;
      if (fa < HEADER_BYTES) return;
      blk = fa - HEADER_BYTES;
      if (blk < NODE_BYTES || blk % NODE_BYTES != 0 || blk >= pool) return;
      tot = span[slot_ix(blk)];
      if (tot == 0 || tot % NODE_BYTES != 0 || tot > pool - blk) return;
      prev = 0;
      for (int k = 0; k < SLOTS; k++) begin
        np = link[slot_ix(prev)];
        if (np == 0 || np >= blk) break;
        prev = np;
      end
      ps = slot_ix(prev);
      if (link[ps] == blk) return;
      cs = slot_ix(blk);
      link[cs] = link[ps];
      span[cs] = tot;
      link[ps] = blk;
      cur = blk;
      if (prev + span[ps] == blk) begin
        span[ps] += span[cs];
        link[ps] = link[cs];
        cur = prev;
        cs = ps;
      end
      np = link[cs];
      if (np != 0 && cur + span[cs] == np) begin
        ns = slot_ix(np);
        span[cs] += span[ns];
        link[cs] = link[ns];
      end
    endfunction

    // accepted request transfer: predict its result
    function int unsigned note_request(logic rt, logic [CNT_W-1:0] cnt,
                                       logic [CNT_W-1:0] bytes, logic [DADDR_W-1:0] fa);
      alloc_result_t r;
      int unsigned a;
      a = 0;
      if (rt == REQ_ALLOC) begin
        r.status = take_block(cnt, bytes, a);
        if (r.status != ST_ALLOC) a = 0;
        if (r.status == ST_ALLOC) n_alloc++;
        else n_nofit++;
      end else begin
        give_back(fa);
        r.status = ST_FREED;
        n_free++;
      end
      r.addr = a[DADDR_W-1:0];
      pending_q.push_back(r);
      return a;
    endfunction

    // result transfer: compare against the oldest prediction
    function void check_result(logic [1:0] st, logic [DADDR_W-1:0] addr);
      alloc_result_t e;
      n_checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d addr %0d", st, addr);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status || addr !== e.addr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d addr %0d, got status %0d addr %0d",
                   e.status, e.addr, st, addr);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_req_type;
  logic [CNT_W-1:0]   in_item_count;
  logic [CNT_W-1:0]   in_item_bytes;
  logic [DADDR_W-1:0] in_free_addr;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [DADDR_W-1:0] out_data_addr;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [ADDR_W-1:0]  cfg_pool_bytes;

  alloc_scoreboard sb;
  int unsigned     live_addrs[$];
  int              burst_mode;

  free_list_pool_allocator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_item_count(in_item_count),
    .in_item_bytes(in_item_bytes), .in_free_addr(in_free_addr),
    .out_valid(out_valid), .out_status(out_status), .out_data_addr(out_data_addr),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_pool_bytes(cfg_pool_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_data_addr);
  end

  // one request transfer; start stays high until the caller idles
  task automatic send(logic rt, logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] bytes,
                      logic [DADDR_W-1:0] fa);
    int unsigned a;
    start         <= 1'b1;
    in_req_type   <= rt;
    in_item_count <= cnt;
    in_item_bytes <= bytes;
    in_free_addr  <= fa;
    do @(posedge clk); while (busy);
    a = sb.note_request(rt, cnt, bytes, fa);
    if (rt == REQ_ALLOC && a != 0) live_addrs.push_back(a);
  endtask

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return;
    if (r < 92) idle($urandom_range(1, 4));
    else idle($urandom_range(20, 90));
  endtask

  // wait out every expected result plus the tail of the last walk
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pool(logic [ADDR_W-1:0] v);
    drain();
    cfg_valid      <= 1'b1;
    cfg_pool_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_pool(v);
    cfg_valid <= 1'b0;
    live_addrs.delete();
  endtask

  // random traffic: mostly well-formed alloc/free pairs, some noise
  task automatic random_items(int n);
    int r, k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send(REQ_ALLOC, $urandom_range(0, 8), $urandom_range(0, 40), $urandom);
      end else if (r < 52) begin
        send(REQ_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom);
      end else if (r < 56) begin
        send(REQ_ALLOC, 1, $urandom_range(100, 4100), $urandom);
      end else if (r < 90 && live_addrs.size() != 0) begin
        k = $urandom_range(0, live_addrs.size() - 1);
        send(REQ_FREE, $urandom, $urandom, live_addrs[k]);
        live_addrs.delete(k);
      end else begin
        send(REQ_FREE, $urandom, $urandom, $urandom);
      end
      random_gap();
      if (i == n / 2 && n > 40) drain();
    end
  endtask

  initial begin
    sb = new();
    sb.set_pool(4096);
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_req_type    <= REQ_ALLOC;
    in_item_count  <= '0;
    in_item_bytes  <= '0;
    in_free_addr   <= '0;
    cfg_valid      <= 1'b0;
    cfg_pool_bytes <= '0;
    burst_mode     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, bad frees, merges
    send(REQ_ALLOC, 0, 0, 0);
    send(REQ_ALLOC, 8191, 8191, 0);
    send(REQ_ALLOC, 1, 4089, 0);
    send(REQ_ALLOC, 4, 4, 0);
    send(REQ_ALLOC, 2, 12, 0);
    send(REQ_FREE, 0, 0, 0);
    send(REQ_FREE, 0, 0, 3);
    send(REQ_FREE, 0, 0, 8);
    send(REQ_FREE, 0, 0, 4095);
    send(REQ_FREE, 0, 0, 24);
    send(REQ_FREE, 0, 0, 24);
    send(REQ_FREE, 0, 0, 16);
    send(REQ_FREE, 0, 0, 56);
    idle(3);
    write_pool(4096);
    send(REQ_ALLOC, 1, 4072, 0);
    send(REQ_ALLOC, 0, 5, 0);
    send(REQ_ALLOC, 0, 0, 0);
    send(REQ_FREE, 0, 0, 16);
    send(REQ_FREE, 0, 0, 0);
    send(REQ_ALLOC, 1, 1, 0);
    write_pool(16);
    send(REQ_ALLOC, 0, 0, 0);
    send(REQ_ALLOC, 0, 0, 0);
    send(REQ_FREE, 0, 0, 16);
    send(REQ_ALLOC, 1, 1, 0);

    // random phases across pool settings
    write_pool(8191);
    random_items(150);
    write_pool(0);
    random_items(30);
    write_pool(1000);
    burst_mode = 1;
    random_items(100);
    burst_mode = 0;
    write_pool(13'h0AAA);
    random_items(120);
    write_pool(13'h1555);
    random_items(100);
    write_pool($urandom_range(16, 4096));
    random_items(60);
    write_pool(4096);
    random_items(70);

    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d allocations, %0d failed fits and %0d frees over 9 pool settings",
             sb.n_alloc, sb.n_nofit, sb.n_free);
    $display("%0d results checked, %0d mismatches", sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASS free_list_pool_allocator_unit");
    end else begin
      $display("FAIL free_list_pool_allocator_unit");
    end
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("timeout");
    $display("FAIL free_list_pool_allocator_unit");
    $finish;
  end

endmodule
